/* design/etsq_pkg.sv */
// ----------------------------------------------------------------------------
// etsq_pkg
// Shared types, codes and the tone pattern ROM of the event tone sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package etsq_pkg;

  // Action codes of an input request
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_TRIGGER = 2'd1;
  localparam logic [1:0] ACT_PLAY    = 2'd2;

  // Speaker commands
  localparam logic CMD_STOP  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam int unsigned RomRows  = 15;
  localparam int unsigned RomCols  = 3;
  localparam int unsigned QueDepth = 4;
  localparam int unsigned QuePtrW  = $clog2(QueDepth);

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  event_code;
    logic [15:0] tone_freq;
    logic [15:0] tone_duration;
  } req_t;

  typedef struct packed {
    logic        command;
    logic [15:0] frequency;
    logic        last;
  } rsp_t;

  // Results produced by one request, in order
  typedef struct packed {
    logic [1:0] count;
    rsp_t       first;
    rsp_t       second;
  } push_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] dur;
    logic [15:0] gap;
  } step_t;

  function automatic logic [1:0] rom_count(input logic [3:0] id);
    logic [1:0] c;
    case (id)
      4'd0, 4'd3, 4'd4, 4'd6, 4'd7, 4'd12, 4'd13, 4'd14: c = 2'd3;
      4'd10:   c = 2'd1;
      4'd15:   c = 2'd0;
      default: c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic step_t rom_step(input logic [3:0] id, input logic [1:0] idx);
    step_t s;
    s = '0;
    case ({id, idx})
      {4'd0, 2'd0}:  s = '{16'd1000, 16'd120, 16'd40};
      {4'd0, 2'd1}:  s = '{16'd1300, 16'd120, 16'd40};
      {4'd0, 2'd2}:  s = '{16'd1600, 16'd180, 16'd0};
      {4'd1, 2'd0}:  s = '{16'd900,  16'd140, 16'd50};
      {4'd1, 2'd1}:  s = '{16'd1100, 16'd140, 16'd0};
      {4'd2, 2'd0}:  s = '{16'd1400, 16'd120, 16'd40};
      {4'd2, 2'd1}:  s = '{16'd1700, 16'd160, 16'd0};
      {4'd3, 2'd0}:  s = '{16'd1200, 16'd100, 16'd40};
      {4'd3, 2'd1}:  s = '{16'd1500, 16'd100, 16'd40};
      {4'd3, 2'd2}:  s = '{16'd1800, 16'd140, 16'd0};
      {4'd4, 2'd0}:  s = '{16'd1000, 16'd100, 16'd40};
      {4'd4, 2'd1}:  s = '{16'd1400, 16'd100, 16'd40};
      {4'd4, 2'd2}:  s = '{16'd1700, 16'd140, 16'd0};
      {4'd5, 2'd0}:  s = '{16'd1500, 16'd160, 16'd50};
      {4'd5, 2'd1}:  s = '{16'd1800, 16'd100, 16'd0};
      {4'd6, 2'd0}:  s = '{16'd900,  16'd100, 16'd40};
      {4'd6, 2'd1}:  s = '{16'd1200, 16'd100, 16'd40};
      {4'd6, 2'd2}:  s = '{16'd1500, 16'd140, 16'd0};
      {4'd7, 2'd0}:  s = '{16'd1100, 16'd100, 16'd40};
      {4'd7, 2'd1}:  s = '{16'd1300, 16'd100, 16'd40};
      {4'd7, 2'd2}:  s = '{16'd1600, 16'd140, 16'd0};
      {4'd8, 2'd0}:  s = '{16'd1800, 16'd160, 16'd60};
      {4'd8, 2'd1}:  s = '{16'd2200, 16'd100, 16'd0};
      {4'd9, 2'd0}:  s = '{16'd1000, 16'd140, 16'd40};
      {4'd9, 2'd1}:  s = '{16'd1200, 16'd100, 16'd0};
      {4'd10, 2'd0}: s = '{16'd2000, 16'd60,  16'd0};
      {4'd11, 2'd0}: s = '{16'd1600, 16'd100, 16'd40};
      {4'd11, 2'd1}: s = '{16'd1400, 16'd80,  16'd0};
      {4'd12, 2'd0}: s = '{16'd900,  16'd140, 16'd60};
      {4'd12, 2'd1}: s = '{16'd1200, 16'd140, 16'd60};
      {4'd12, 2'd2}: s = '{16'd1500, 16'd180, 16'd0};
      {4'd13, 2'd0}: s = '{16'd1100, 16'd140, 16'd60};
      {4'd13, 2'd1}: s = '{16'd1400, 16'd140, 16'd60};
      {4'd13, 2'd2}: s = '{16'd1700, 16'd180, 16'd0};
      {4'd14, 2'd0}: s = '{16'd800,  16'd140, 16'd70};
      {4'd14, 2'd1}: s = '{16'd1000, 16'd140, 16'd70};
      {4'd14, 2'd2}: s = '{16'd1200, 16'd200, 16'd0};
      default:       s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* design/event_tone_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// event_tone_sequencer_unit
// Buzzer pattern player: ticks, pattern triggers and direct tone requests.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the result queue has room; a tick with a stop
// and a start gives two results, and a four-entry result queue absorbs the burst.
// An accepted request is held in the input register, then the state update writes
// its results into the result queue once the queue has room.
// Reset clears time, tone and pattern state and empties the queue at once.
`default_nettype none

module event_tone_sequencer_unit #(
  parameter int unsigned PATTERN_COUNT = 15,
  parameter int unsigned MAX_STEPS     = 3
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire etsq_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output etsq_pkg::rsp_t      out_data_o
);

  logic            req_valid_q, req_valid_d;
  etsq_pkg::req_t  req_q;
  logic            room, advance;
  etsq_pkg::push_t push;

  // advance the held request only when the queue can take its results
  assign advance     = req_valid_q && room;
  assign in_ready_o  = !req_valid_q || advance;
  assign req_valid_d = in_ready_o ? in_valid_i : req_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
  end

  etsq_core #(
    .PATTERN_COUNT(PATTERN_COUNT),
    .MAX_STEPS    (MAX_STEPS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(advance),
    .req_i  (req_q),
    .push_o (push)
  );

  etsq_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

/* design/etsq_core.sv */
// ----------------------------------------------------------------------------
// etsq_core
// Sequencer state and the per-request update: time, tone and pattern steps.
// ----------------------------------------------------------------------------
`default_nettype none

module etsq_core #(
  parameter int unsigned PATTERN_COUNT = 15,
  parameter int unsigned MAX_STEPS     = 3
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire etsq_pkg::req_t req_i,
  output etsq_pkg::push_t     push_o
);

  logic [31:0] elapsed_q, elapsed_d;
  logic        tone_on_q, tone_on_d;
  logic [31:0] tone_end_q, tone_end_d;
  logic        running_q, running_d;
  logic [3:0]  pat_id_q, pat_id_d;
  logic [1:0]  step_q, step_d;
  logic [31:0] next_step_q, next_step_d;

  logic [31:0]     tick_ms;
  logic            stop_hit, tone_kept, step_due, pat_done;
  logic [1:0]      limit;
  etsq_pkg::step_t step;
  etsq_pkg::rsp_t  stop_rsp, start_rsp;

  always_comb begin
    limit = etsq_pkg::rom_count(pat_id_q);
    if (32'(limit) > MAX_STEPS) begin
      limit = 2'(MAX_STEPS);
    end
  end

  assign tick_ms   = elapsed_q + 32'd1;
  assign stop_hit  = tone_on_q && (tick_ms >= tone_end_q);
  assign tone_kept = tone_on_q && !stop_hit;
  assign step_due  = running_q && !tone_kept && (tick_ms >= next_step_q);
  assign pat_done  = (32'(pat_id_q) >= etsq_pkg::RomRows) || (step_q >= limit);
  assign step      = etsq_pkg::rom_step(pat_id_q, step_q);

  always_comb begin
    elapsed_d   = elapsed_q;
    tone_on_d   = tone_on_q;
    tone_end_d  = tone_end_q;
    running_d   = running_q;
    pat_id_d    = pat_id_q;
    step_d      = step_q;
    next_step_d = next_step_q;
    stop_rsp    = '{etsq_pkg::CMD_STOP, 16'd0, 1'b0};
    start_rsp   = '{etsq_pkg::CMD_START, step.freq, 1'b1};
    push_o      = '0;

    if (valid_i) begin
      case (req_i.action)
        etsq_pkg::ACT_TICK: begin
          elapsed_d = tick_ms;
          if (stop_hit) begin
            tone_on_d = 1'b0;
          end
          if (step_due && pat_done) begin
            running_d = 1'b0;
          end else if (step_due) begin
            tone_end_d  = tick_ms + 32'(step.dur);
            tone_on_d   = 1'b1;
            next_step_d = tick_ms + 32'(step.dur) + 32'(step.gap);
            step_d      = step_q + 2'd1;
          end
          // order results: stop before start, last on the final one
          if (stop_hit && step_due && !pat_done) begin
            push_o = '{2'd2, stop_rsp, start_rsp};
          end else if (stop_hit) begin
            stop_rsp.last = 1'b1;
            push_o = '{2'd1, stop_rsp, start_rsp};
          end else if (step_due && !pat_done) begin
            push_o = '{2'd1, start_rsp, start_rsp};
          end
        end
        etsq_pkg::ACT_TRIGGER: begin
          if (32'(req_i.event_code) < PATTERN_COUNT &&
              32'(req_i.event_code) < etsq_pkg::RomRows) begin
            pat_id_d    = req_i.event_code;
            step_d      = 2'd0;
            next_step_d = 32'd0;
            running_d   = 1'b1;
          end
        end
        etsq_pkg::ACT_PLAY: begin
          if (req_i.tone_freq != 16'd0 && req_i.tone_duration != 16'd0) begin
            tone_end_d = elapsed_q + 32'(req_i.tone_duration);
            tone_on_d  = 1'b1;
            push_o     = '{2'd1, '{etsq_pkg::CMD_START, req_i.tone_freq, 1'b1}, stop_rsp};
          end
        end
        default: begin
          // unused action: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      tone_on_q   <= 1'b0;
      tone_end_q  <= '0;
      running_q   <= 1'b0;
      pat_id_q    <= '0;
      step_q      <= '0;
      next_step_q <= '0;
    end else begin
      elapsed_q   <= elapsed_d;
      tone_on_q   <= tone_on_d;
      tone_end_q  <= tone_end_d;
      running_q   <= running_d;
      pat_id_q    <= pat_id_d;
      step_q      <= step_d;
      next_step_q <= next_step_d;
    end
  end

endmodule

`default_nettype wire

/* design/etsq_res_fifo.sv */
// ----------------------------------------------------------------------------
// etsq_res_fifo
// Result queue: takes up to two results per cycle, hands out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module etsq_res_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire etsq_pkg::push_t push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output etsq_pkg::rsp_t       out_data_o
);

  localparam int unsigned PtrW = etsq_pkg::QuePtrW;
  localparam int unsigned CntW = PtrW + 1;

  etsq_pkg::rsp_t mem_q [etsq_pkg::QueDepth];
  logic [PtrW-1:0] rd_q, rd_d, wr_q, wr_d, wr_nxt;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  // keep space for the largest burst of one request
  assign room_o      = (cnt_q <= CntW'(etsq_pkg::QueDepth - 2));
  assign wr_nxt      = wr_q + PtrW'(1);

  always_comb begin
    rd_d  = rd_q + PtrW'(pop);
    wr_d  = wr_q + PtrW'(push_i.count);
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_nxt] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* test/event_tone_sequencer_unit_test.sv */
// ----------------------------------------------------------------------------
// event_tone_sequencer_unit_test
// Self-checking bench for the buzzer pattern player: directed requests for the
// ignored, single-tone and pattern-takeover cases, a long output stall that
// fills the result queue, then random pattern runs with ticks and noise.
// Every speaker command is checked against a cycle-free model of the player.
// ----------------------------------------------------------------------------
`default_nettype none

module event_tone_sequencer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ACT_UNUSED      = 2'd3;
  localparam int unsigned PATTERNS        = 15;
  localparam int unsigned STEP_CAP        = 3;
  localparam int unsigned RANDOM_REQUESTS = 1600;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned MAX_RUN_TICKS   = 900;
  localparam int unsigned CYCLE_LIMIT     = 10_000_000;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  etsq_pkg::req_t in_data_i;
  logic           out_valid_o;
  logic           out_ready_i;
  etsq_pkg::rsp_t out_data_o;

  event_tone_sequencer_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Player model state
  bit [31:0] now_ms;
  bit        tone_active;
  bit [31:0] tone_stop_ms;
  bit        seq_active;
  bit [3:0]  seq_id;
  bit [1:0]  seq_step;
  bit [31:0] seq_next_ms;
  bit        pattern_done [PATTERNS];

  etsq_pkg::rsp_t speaker_cmds_due[$];
  int unsigned    requests_sent;
  int unsigned    cmds_checked;
  int unsigned    error_count;
  int unsigned    cycle_count;
  bit             gaps_enabled;
  bit             hold_off_req;
  bit             input_held;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pattern_length(input logic [3:0] id);
    int unsigned n;
    case (id)
      4'd0, 4'd3, 4'd4, 4'd6, 4'd7, 4'd12, 4'd13, 4'd14: n = 3;
      4'd10:   n = 1;
      default: n = 2;
    endcase
    return (n > STEP_CAP) ? STEP_CAP : n;
  endfunction

  function automatic etsq_pkg::step_t pattern_tone(input logic [3:0] id,
                                                   input logic [1:0] idx);
    etsq_pkg::step_t s;
    s = '0;
    case ({id, idx})
      {4'd0, 2'd0}:  s = '{16'd1000, 16'd120, 16'd40};
      {4'd0, 2'd1}:  s = '{16'd1300, 16'd120, 16'd40};
      {4'd0, 2'd2}:  s = '{16'd1600, 16'd180, 16'd0};
      {4'd1, 2'd0}:  s = '{16'd900,  16'd140, 16'd50};
      {4'd1, 2'd1}:  s = '{16'd1100, 16'd140, 16'd0};
      {4'd2, 2'd0}:  s = '{16'd1400, 16'd120, 16'd40};
      {4'd2, 2'd1}:  s = '{16'd1700, 16'd160, 16'd0};
      {4'd3, 2'd0}:  s = '{16'd1200, 16'd100, 16'd40};
      {4'd3, 2'd1}:  s = '{16'd1500, 16'd100, 16'd40};
      {4'd3, 2'd2}:  s = '{16'd1800, 16'd140, 16'd0};
      {4'd4, 2'd0}:  s = '{16'd1000, 16'd100, 16'd40};
      {4'd4, 2'd1}:  s = '{16'd1400, 16'd100, 16'd40};
      {4'd4, 2'd2}:  s = '{16'd1700, 16'd140, 16'd0};
      {4'd5, 2'd0}:  s = '{16'd1500, 16'd160, 16'd50};
      {4'd5, 2'd1}:  s = '{16'd1800, 16'd100, 16'd0};
      {4'd6, 2'd0}:  s = '{16'd900,  16'd100, 16'd40};
      {4'd6, 2'd1}:  s = '{16'd1200, 16'd100, 16'd40};
      {4'd6, 2'd2}:  s = '{16'd1500, 16'd140, 16'd0};
      {4'd7, 2'd0}:  s = '{16'd1100, 16'd100, 16'd40};
      {4'd7, 2'd1}:  s = '{16'd1300, 16'd100, 16'd40};
      {4'd7, 2'd2}:  s = '{16'd1600, 16'd140, 16'd0};
      {4'd8, 2'd0}:  s = '{16'd1800, 16'd160, 16'd60};
      {4'd8, 2'd1}:  s = '{16'd2200, 16'd100, 16'd0};
      {4'd9, 2'd0}:  s = '{16'd1000, 16'd140, 16'd40};
      {4'd9, 2'd1}:  s = '{16'd1200, 16'd100, 16'd0};
      {4'd10, 2'd0}: s = '{16'd2000, 16'd60,  16'd0};
      {4'd11, 2'd0}: s = '{16'd1600, 16'd100, 16'd40};
      {4'd11, 2'd1}: s = '{16'd1400, 16'd80,  16'd0};
      {4'd12, 2'd0}: s = '{16'd900,  16'd140, 16'd60};
      {4'd12, 2'd1}: s = '{16'd1200, 16'd140, 16'd60};
      {4'd12, 2'd2}: s = '{16'd1500, 16'd180, 16'd0};
      {4'd13, 2'd0}: s = '{16'd1100, 16'd140, 16'd60};
      {4'd13, 2'd1}: s = '{16'd1400, 16'd140, 16'd60};
      {4'd13, 2'd2}: s = '{16'd1700, 16'd180, 16'd0};
      {4'd14, 2'd0}: s = '{16'd800,  16'd140, 16'd70};
      {4'd14, 2'd1}: s = '{16'd1000, 16'd140, 16'd70};
      {4'd14, 2'd2}: s = '{16'd1200, 16'd200, 16'd0};
      default:       s = '0;
    endcase
    return s;
  endfunction

  // Advance the player model by one request and queue the commands it causes
  task automatic predict_commands(input etsq_pkg::req_t r, output bit acted);
    etsq_pkg::rsp_t  cmds[$];
    etsq_pkg::rsp_t  c;
    etsq_pkg::step_t s;
    acted = 1'b1;
    case (r.action)
      etsq_pkg::ACT_TICK: begin
        now_ms = now_ms + 32'd1;
        if (tone_active && now_ms >= tone_stop_ms) begin
          c = '{command: etsq_pkg::CMD_STOP, frequency: 16'd0, last: 1'b0};
          cmds.push_back(c);
          tone_active = 1'b0;
        end
        if (seq_active && !tone_active && now_ms >= seq_next_ms) begin
          if (seq_step >= pattern_length(seq_id)) begin
            seq_active = 1'b0;
            pattern_done[seq_id] = 1'b1;
          end else begin
            s = pattern_tone(seq_id, seq_step);
            c = '{command: etsq_pkg::CMD_START, frequency: s.freq, last: 1'b0};
            cmds.push_back(c);
            tone_stop_ms = now_ms + s.dur;
            tone_active  = 1'b1;
            seq_next_ms  = tone_stop_ms + s.gap;
            seq_step     = seq_step + 2'd1;
          end
        end
      end
      etsq_pkg::ACT_TRIGGER: begin
        if (r.event_code < PATTERNS) begin
          seq_id      = r.event_code;
          seq_step    = 2'd0;
          seq_next_ms = 32'd0;
          seq_active  = 1'b1;
        end else begin
          acted = 1'b0;
        end
      end
      etsq_pkg::ACT_PLAY: begin
        if (r.tone_freq != 16'd0 && r.tone_duration != 16'd0) begin
          c = '{command: etsq_pkg::CMD_START, frequency: r.tone_freq, last: 1'b0};
          cmds.push_back(c);
          tone_stop_ms = now_ms + r.tone_duration;
          tone_active  = 1'b1;
        end else begin
          acted = 1'b0;
        end
      end
      default: acted = 1'b0;
    endcase
    for (int i = 0; i < cmds.size(); i++) begin
      c = cmds[i];
      c.last = (i == cmds.size() - 1);
      speaker_cmds_due.push_back(c);
    end
  endtask

  function automatic int unsigned idle_length();
    if (!gaps_enabled) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic etsq_pkg::req_t make_request(input logic [1:0] action,
                                                  input logic [3:0] code,
                                                  input logic [15:0] freq,
                                                  input logic [15:0] dur);
    etsq_pkg::req_t r;
    r.action        = action;
    r.event_code    = code;
    r.tone_freq     = freq;
    r.tone_duration = dur;
    return r;
  endfunction

  // Tick with junk in the fields it does not use
  function automatic etsq_pkg::req_t tick_request();
    return make_request(etsq_pkg::ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  function automatic etsq_pkg::req_t noise_request();
    logic [15:0] freq;
    logic [15:0] dur;
    int unsigned pick;
    freq = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0)      dur = 16'd0;
    else if (pick == 1) dur = 16'($urandom);
    else                dur = 16'($urandom_range(1, 300));
    return make_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), freq, dur);
  endfunction

  // Prefer a pattern that has not yet played to its end
  function automatic int unsigned next_pattern_code();
    int unsigned first;
    int unsigned id;
    first = $urandom_range(0, PATTERNS - 1);
    if ($urandom_range(0, 2) != 0) begin
      for (int i = 0; i < PATTERNS; i++) begin
        id = (first + i) % PATTERNS;
        if (!pattern_done[id]) return id;
      end
    end
    return first;
  endfunction

  // Offer one request and hold it until accepted; valid stays high afterwards
  task automatic send_request(input etsq_pkg::req_t r);
    int unsigned gap;
    bit          acted;
    gap = idle_length();
    if (gap > 0) begin
      if (input_held) begin
        in_valid_i <= 1'b0;
        input_held = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    input_held = 1'b1;
    do @(negedge clk_i); while (in_ready_o !== 1'b1);
    @(posedge clk_i);
    predict_commands(r, acted);
    if (acted) requests_sent++;
  endtask

  task automatic wait_for_speaker_idle();
    if (input_held) begin
      in_valid_i <= 1'b0;
      input_held = 1'b0;
    end
    do @(posedge clk_i); while (speaker_cmds_due.size() != 0);
  endtask

  task automatic test_ignored_requests();
    send_request(tick_request());
    send_request(make_request(ACT_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(etsq_pkg::ACT_PLAY, 4'h0, 16'd0, 16'hFFFF));
    send_request(make_request(etsq_pkg::ACT_PLAY, 4'hF, 16'hFFFF, 16'd0));
    send_request(make_request(etsq_pkg::ACT_TRIGGER, 4'hF, 16'hFFFF, 16'hFFFF));
    wait_for_speaker_idle();
  endtask

  task automatic test_single_tones();
    send_request(make_request(etsq_pkg::ACT_PLAY, 4'h0, 16'hFFFF, 16'd1));
    send_request(tick_request());
    wait_for_speaker_idle();
  endtask

  task automatic test_pattern_triggers();
    send_request(make_request(etsq_pkg::ACT_TRIGGER, 4'd10, 16'h0000, 16'h0000));
    send_request(make_request(etsq_pkg::ACT_PLAY, 4'h0, 16'd1, 16'd1));
    // stop of the short tone and first pattern step on the same tick
    send_request(tick_request());
    send_request(make_request(etsq_pkg::ACT_PLAY, 4'h0, 16'hFFFF, 16'hFFFF));
    send_request(tick_request());
    send_request(make_request(etsq_pkg::ACT_TRIGGER, 4'd0, 16'h0000, 16'h0000));
    send_request(make_request(etsq_pkg::ACT_TRIGGER, 4'd14, 16'hFFFF, 16'hFFFF));
    send_request(make_request(etsq_pkg::ACT_PLAY, 4'h0, 16'h8000, 16'd2));
    repeat (3) send_request(tick_request());
    wait_for_speaker_idle();
  endtask

  task automatic test_backpressure();
    gaps_enabled = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) begin
      send_request(make_request(etsq_pkg::ACT_PLAY, 4'($urandom),
                                16'($urandom_range(1, 65535)),
                                16'($urandom_range(1, 500))));
    end
    gaps_enabled = 1'b1;
    wait_for_speaker_idle();
  endtask

  task automatic test_random_patterns();
    int unsigned target;
    int unsigned code;
    int unsigned ticks;
    target = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < target) begin
      gaps_enabled = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(10, 30)) send_request(noise_request());
      end else begin
        code = next_pattern_code();
        send_request(make_request(etsq_pkg::ACT_TRIGGER, 4'(code), 16'($urandom),
                                  16'($urandom)));
        ticks = 0;
        while (seq_active && ticks < MAX_RUN_TICKS && requests_sent < target) begin
          if ($urandom_range(0, 59) == 0) send_request(noise_request());
          else                            send_request(tick_request());
          ticks++;
        end
      end
      // cut a very long tone short so the next pattern is not starved
      if (tone_active && tone_stop_ms - now_ms > 400) begin
        send_request(make_request(etsq_pkg::ACT_PLAY, 4'($urandom),
                                  16'($urandom_range(1, 65535)), 16'd1));
      end
    end
    gaps_enabled = 1'b1;
    wait_for_speaker_idle();
  endtask

  // Speaker side: random ready, with one long hold-off on request
  initial begin : speaker_side
    int unsigned run_left;
    int unsigned stall_left;
    run_left   = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        run_left   = 0;
        stall_left = 0;
      end else if (!gaps_enabled) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_ready_i <= 1'b1;
      end else begin
        run_left   = $urandom_range(0, 24);
        stall_left = idle_length();
        out_ready_i <= 1'b1;
      end
    end
  end

  // Sample mid-cycle: a command seen here is taken at the next rising edge
  always @(negedge clk_i) begin : speaker_check
    etsq_pkg::rsp_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (speaker_cmds_due.size() == 0) begin
        $error("unexpected speaker command: command %0b frequency %0d last %0b",
               out_data_o.command, out_data_o.frequency, out_data_o.last);
        error_count++;
      end else begin
        want = speaker_cmds_due.pop_front();
        cmds_checked++;
        if (out_data_o.command !== want.command) begin
          $error("command: expected %0b, actual %0b", want.command, out_data_o.command);
          error_count++;
        end
        if (out_data_o.frequency !== want.frequency) begin
          $error("frequency: expected %0d, actual %0d", want.frequency,
                 out_data_o.frequency);
          error_count++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_data_o.last);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : run_tests
    int unsigned finished;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    gaps_enabled = 1'b1;
    hold_off_req = 1'b0;
    input_held   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_requests();
    test_single_tones();
    test_pattern_triggers();
    test_backpressure();
    test_random_patterns();

    wait_for_speaker_idle();
    repeat (10) @(posedge clk_i);

    finished = 0;
    foreach (pattern_done[i]) if (pattern_done[i]) finished++;
    $display("Run covered %0d effective requests and %0d checked speaker commands,",
             requests_sent, cmds_checked);
    $display("with a %0d-cycle output stall and %0d of %0d patterns played to their end.",
             HOLD_OFF_CYCLES, finished, PATTERNS);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
